@@ rtl/lru_et_pkg.sv @@
// lru_et_pkg: shared constants, result type and helpers for the lru eviction tracker
// no dependencies; imported by the top, front and engine, and used by the fifo for its depth
`default_nettype none

package lru_et_pkg;

    localparam int unsigned ADDR_SPACE_DEF = 65536;
    localparam int unsigned CAP_MAX_DEF    = 1024;
    localparam int unsigned TIME_BITS_DEF  = 32;
    localparam int unsigned FIFO_DEPTH     = 2;
    localparam int unsigned ADDR_W         = 16;
    localparam int unsigned CFG_W          = 11;
    localparam logic [CFG_W-1:0] CAP_RESET = 11'd1024;

    typedef struct packed {
        logic        hit;
        logic        evicted;
        logic [15:0] evictee;
        logic [31:0] since_last_ref;
        logic [31:0] since_entered;
        logic [31:0] access_total;
        logic [31:0] miss_total;
        logic [31:0] fill_mark;
        logic [31:0] evict_total;
        logic [63:0] age_sum;
        logic [63:0] age_square_sum;
        logic        batch_last;
    } t_result;

    function automatic logic [63:0] f_sat_add64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/lru_eviction_tracker_top.sv @@
// lru_eviction_tracker_top: lru cache replacement tracker, front stage, queues and engine
// depends on lru_et_pkg, lru_et_front, lru_et_fifo, lru_et_engine
//
// channel   direction  handshake               beat
// input     in         push / full             addr, batch_end
// result    out        empty / pop             hit .. batch_last
// config    in         cfg_valid / cfg_ready   capacity
//
// the front holds full after each beat while it reduces the address and until the queue in
// front of the engine takes it; the engine steps through the registered reads of the rams,
// skipping holes in the queue when it evicts and repacking the queue when its head is full.
// after reset a clearing pass over the residency and queue rams holds full high.
// a full result queue stalls the engine; the two queues let front and engine stall apart.
`default_nettype none

module lru_eviction_tracker_top #(
    parameter int unsigned ADDR_SPACE = lru_et_pkg::ADDR_SPACE_DEF,
    parameter int unsigned CAP_MAX    = lru_et_pkg::CAP_MAX_DEF,
    parameter int unsigned TIME_BITS  = lru_et_pkg::TIME_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [lru_et_pkg::ADDR_W-1:0] i_addr,
    input  wire logic                          i_batch_end,
    output logic                               empty,
    input  wire logic                          pop,
    output logic                               o_hit,
    output logic                               o_evicted,
    output logic [15:0]                        o_evictee,
    output logic [31:0]                        o_since_last_ref,
    output logic [31:0]                        o_since_entered,
    output logic [31:0]                        o_access_total,
    output logic [31:0]                        o_miss_total,
    output logic [31:0]                        o_fill_mark,
    output logic [31:0]                        o_evict_total,
    output logic [63:0]                        o_age_sum,
    output logic [63:0]                        o_age_square_sum,
    output logic                               o_batch_last,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [lru_et_pkg::CFG_W-1:0]  i_cfg_data
);
    import lru_et_pkg::*;

    localparam int unsigned AW = $clog2(ADDR_SPACE);

    logic [CFG_W-1:0] r_cap;
    logic             front_busy;
    logic             clearing;
    logic             take;
    logic             mid_push;
    logic [AW:0]      mid_wdata;
    logic             mid_full;
    logic             mid_pop;
    logic [AW:0]      mid_rdata;
    logic             mid_empty;
    logic             res_push;
    t_result          res_wdata;
    logic             res_full;
    t_result          res_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cap <= i_cfg_data;
        end
    end

    assign full = front_busy || clearing;
    assign take = push && !full;

    lru_et_front #(.ADDR_SPACE(ADDR_SPACE)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_addr      (i_addr),
        .i_batch_end (i_batch_end),
        .o_busy      (front_busy),
        .o_push      (mid_push),
        .o_data      (mid_wdata),
        .i_fifo_full (mid_full)
    );

    lru_et_fifo #(.W(AW + 1)) u_mid_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_data  (mid_wdata),
        .o_full  (mid_full),
        .i_pop   (mid_pop),
        .o_data  (mid_rdata),
        .o_empty (mid_empty)
    );

    lru_et_engine #(
        .ADDR_SPACE (ADDR_SPACE),
        .CAP_MAX    (CAP_MAX),
        .TIME_BITS  (TIME_BITS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cap       (r_cap),
        .i_mid_empty (mid_empty),
        .i_mid_data  (mid_rdata),
        .o_mid_pop   (mid_pop),
        .o_res_push  (res_push),
        .o_res       (res_wdata),
        .i_res_full  (res_full),
        .o_clearing  (clearing)
    );

    lru_et_fifo #(.W($bits(t_result))) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_wdata),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_rdata),
        .o_empty (empty)
    );

    assign o_hit            = res_rdata.hit;
    assign o_evicted        = res_rdata.evicted;
    assign o_evictee        = res_rdata.evictee;
    assign o_since_last_ref = res_rdata.since_last_ref;
    assign o_since_entered  = res_rdata.since_entered;
    assign o_access_total   = res_rdata.access_total;
    assign o_miss_total     = res_rdata.miss_total;
    assign o_fill_mark      = res_rdata.fill_mark;
    assign o_evict_total    = res_rdata.evict_total;
    assign o_age_sum        = res_rdata.age_sum;
    assign o_age_square_sum = res_rdata.age_square_sum;
    assign o_batch_last     = res_rdata.batch_last;

endmodule

`default_nettype wire

@@ rtl/lru_et_ram.sv @@
// lru_et_ram: generic single write port ram with one registered read port
// no dependencies
`default_nettype none

module lru_et_ram #(
    parameter int unsigned W = 8,
    parameter int unsigned D = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]              o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/lru_et_fifo.sv @@
// lru_et_fifo: small register queue between the stages of the tracker
// depends on lru_et_pkg for the default depth
`default_nettype none

module lru_et_fifo #(
    parameter int unsigned W     = 1,
    parameter int unsigned DEPTH = lru_et_pkg::FIFO_DEPTH
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_data,
    output logic              o_empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          w_do_push;
    logic          w_do_pop;

    assign o_full    = (r_cnt == CW'(DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/lru_et_front.sv @@
// lru_et_front: takes one reference beat and reduces its address into the address space
// depends on lru_et_pkg; feeds the queue in front of lru_et_engine
`default_nettype none

module lru_et_front #(
    parameter int unsigned ADDR_SPACE = lru_et_pkg::ADDR_SPACE_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_take,
    input  wire logic [lru_et_pkg::ADDR_W-1:0]   i_addr,
    input  wire logic                            i_batch_end,
    output logic                                 o_busy,
    output logic                                 o_push,
    output logic [$clog2(ADDR_SPACE):0]          o_data,
    input  wire logic                            i_fifo_full
);
    import lru_et_pkg::*;

    localparam int unsigned     AW    = $clog2(ADDR_SPACE);
    localparam bit              PASS  = (ADDR_SPACE >= (1 << ADDR_W));
    localparam int unsigned     LG    = PASS ? ADDR_W : $clog2(ADDR_SPACE);
    localparam int unsigned     SH    = ADDR_W + LG;
    localparam longint unsigned RECIP =
        ((longint'(1) << SH) + longint'(ADDR_SPACE) - 1) / longint'(ADDR_SPACE);
    localparam logic [17:0]     MUL_K = 18'(RECIP);
    localparam logic [16:0]     DIV_K = 17'(ADDR_SPACE);

    logic              r_busy;
    logic              r_done;
    logic [1:0]        r_step;
    logic [ADDR_W-1:0] r_bits;
    logic [33:0]       r_prod;
    logic [32:0]       r_qd;
    logic [ADDR_W-1:0] r_rem;
    logic              r_batch;
    logic [ADDR_W-1:0] w_quot;

    // quotient by reciprocal multiplication, then the remainder
    assign w_quot = ADDR_W'(r_prod >> SH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_take && !r_busy) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (r_busy && !r_done) begin
            r_step <= r_step + 1'b1;
            if (r_step == 2'd2) begin
                r_done <= 1'b1;
            end
        end else if (r_done && !i_fifo_full) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && !r_busy) begin
            r_bits  <= i_addr;
            r_batch <= i_batch_end;
        end else if (r_busy && !r_done) begin
            case (r_step)
                2'd0: r_prod <= 34'(r_bits) * 34'(MUL_K);
                2'd1: r_qd   <= 33'(w_quot) * 33'(DIV_K);
                default: r_rem <= PASS ? r_bits : r_bits - r_qd[ADDR_W-1:0];
            endcase
        end
    end

    assign o_busy = r_busy;
    assign o_push = r_done && !i_fifo_full;
    assign o_data = {r_batch, AW'(r_rem)};

endmodule

`default_nettype wire

@@ rtl/lru_et_engine.sv @@
// lru_et_engine: residency table, recency queue, eviction and running statistics
// depends on lru_et_pkg and lru_et_ram
`default_nettype none

module lru_et_engine #(
    parameter int unsigned ADDR_SPACE = lru_et_pkg::ADDR_SPACE_DEF,
    parameter int unsigned CAP_MAX    = lru_et_pkg::CAP_MAX_DEF,
    parameter int unsigned TIME_BITS  = lru_et_pkg::TIME_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [lru_et_pkg::CFG_W-1:0]  i_cap,
    input  wire logic                          i_mid_empty,
    input  wire logic [$clog2(ADDR_SPACE):0]   i_mid_data,
    output logic                               o_mid_pop,
    output logic                               o_res_push,
    output lru_et_pkg::t_result                o_res,
    input  wire logic                          i_res_full,
    output logic                               o_clearing
);
    import lru_et_pkg::*;

    localparam int unsigned AW    = $clog2(ADDR_SPACE);
    localparam int unsigned QD    = 2 * CAP_MAX;
    localparam int unsigned QW    = $clog2(QD);
    localparam int unsigned OW    = $clog2(CAP_MAX + 2);
    localparam int unsigned TB    = TIME_BITS;
    localparam int unsigned CLR_N = (ADDR_SPACE > QD) ? ADDR_SPACE : QD;
    localparam int unsigned CLRW  = $clog2(CLR_N + 1);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_RES  = 4'd2;
    localparam logic [3:0] S_APP  = 4'd3;
    localparam logic [3:0] S_CRD  = 4'd4;
    localparam logic [3:0] S_CWR  = 4'd5;
    localparam logic [3:0] S_AWR  = 4'd6;
    localparam logic [3:0] S_EVC  = 4'd7;
    localparam logic [3:0] S_ERD  = 4'd8;
    localparam logic [3:0] S_ECHK = 4'd9;
    localparam logic [3:0] S_ETM  = 4'd10;
    localparam logic [3:0] S_EMUL = 4'd11;
    localparam logic [3:0] S_ESQ  = 4'd12;
    localparam logic [3:0] S_OUT  = 4'd13;

    logic [3:0]      r_state;
    logic [3:0]      n_state;
    logic [CLRW-1:0] r_clr;
    logic [AW-1:0]   r_a;
    logic            r_batch;
    logic            r_hit;
    logic            r_ev;
    logic [AW-1:0]   r_evictee;
    logic [31:0]     r_age1;
    logic [31:0]     r_age2;
    logic [QW:0]     r_head;
    logic [QW:0]     r_tail;
    logic [QW:0]     r_i;
    logic [QW:0]     r_j;
    logic [OW-1:0]   r_occ;
    logic [TB-1:0]   r_acc;
    logic [TB-1:0]   r_miss;
    logic [TB-1:0]   r_fill;
    logic [TB-1:0]   r_evc;
    logic [63:0]     r_sum;
    logic [63:0]     r_sq;
    logic [63:0]     r_prod;

    logic [31:0]     w_cap;
    logic [TB-1:0]   w_acc_n;
    logic            w_res_hit;
    logic            w_q_valid;
    logic [AW-1:0]   w_q_addr;

    logic            res_we;
    logic [AW-1:0]   res_waddr;
    logic [QW:0]     res_wdata;
    logic [QW:0]     res_rdata;
    logic            q_we;
    logic [QW-1:0]   q_waddr;
    logic [AW:0]     q_wdata;
    logic [QW-1:0]   q_raddr;
    logic [AW:0]     q_rdata;
    logic            tm_we_last;
    logic            tm_we_enter;
    logic [TB-1:0]   last_rdata;
    logic [TB-1:0]   enter_rdata;

    function automatic logic [31:0] f_clip(input logic [TB-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
    endfunction

    function automatic logic [TB-1:0] f_age(input logic [TB-1:0] now, input logic [TB-1:0] t);
        return (now >= t) ? now - t : '0;
    endfunction

    function automatic logic [TB-1:0] f_inc(input logic [TB-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // capacity of zero acts as one, above the table size as the table size
    always_comb begin
        w_cap = 32'(i_cap);
        if (w_cap == 32'd0) begin
            w_cap = 32'd1;
        end else if (w_cap > CAP_MAX) begin
            w_cap = 32'(CAP_MAX);
        end
    end

    assign w_acc_n   = f_inc(r_acc);
    assign w_res_hit = res_rdata[QW];
    assign w_q_valid = q_rdata[AW];
    assign w_q_addr  = q_rdata[AW-1:0];

    always_comb begin
        res_we    = 1'b0;
        res_waddr = r_a;
        res_wdata = '0;
        q_we      = 1'b0;
        q_waddr   = r_head[QW-1:0];
        q_wdata   = '0;
        unique case (r_state)
            S_CLR: begin
                res_we    = (32'(r_clr) < ADDR_SPACE);
                res_waddr = r_clr[AW-1:0];
                q_we      = (32'(r_clr) < QD);
                q_waddr   = r_clr[QW-1:0];
            end
            S_RES: begin
                q_we    = w_res_hit;
                q_waddr = res_rdata[QW-1:0];
            end
            S_CWR: begin
                res_we    = w_q_valid;
                res_waddr = w_q_addr;
                res_wdata = {1'b1, r_j[QW-1:0]};
                q_we      = w_q_valid;
                q_waddr   = r_j[QW-1:0];
                q_wdata   = {1'b1, w_q_addr};
            end
            S_AWR: begin
                res_we    = 1'b1;
                res_wdata = {1'b1, r_head[QW-1:0]};
                q_we      = 1'b1;
                q_wdata   = {1'b1, r_a};
            end
            S_ECHK: begin
                res_we    = w_q_valid;
                res_waddr = w_q_addr;
                q_we      = w_q_valid;
                q_waddr   = r_tail[QW-1:0];
            end
            default: begin
            end
        endcase
    end

    assign q_raddr     = (r_state == S_CRD) ? r_i[QW-1:0] : r_tail[QW-1:0];
    assign tm_we_last  = (r_state == S_RES);
    assign tm_we_enter = (r_state == S_RES) && !w_res_hit;

    lru_et_ram #(.W(QW + 1), .D(ADDR_SPACE)) u_res_ram (
        .i_clk   (i_clk),
        .i_we    (res_we),
        .i_waddr (res_waddr),
        .i_wdata (res_wdata),
        .i_raddr (i_mid_data[AW-1:0]),
        .o_rdata (res_rdata)
    );

    lru_et_ram #(.W(AW + 1), .D(QD)) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (q_wdata),
        .i_raddr (q_raddr),
        .o_rdata (q_rdata)
    );

    lru_et_ram #(.W(TB), .D(ADDR_SPACE)) u_last_ram (
        .i_clk   (i_clk),
        .i_we    (tm_we_last),
        .i_waddr (r_a),
        .i_wdata (r_acc),
        .i_raddr (w_q_addr),
        .o_rdata (last_rdata)
    );

    lru_et_ram #(.W(TB), .D(ADDR_SPACE)) u_enter_ram (
        .i_clk   (i_clk),
        .i_we    (tm_we_enter),
        .i_waddr (r_a),
        .i_wdata (r_acc),
        .i_raddr (w_q_addr),
        .o_rdata (enter_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:  n_state = (32'(r_clr) == CLR_N - 1) ? S_IDLE : S_CLR;
            S_IDLE: n_state = i_mid_empty ? S_IDLE : S_RES;
            S_RES:  n_state = S_APP;
            S_APP:  n_state = (32'(r_head) >= {w_cap[30:0], 1'b0}) ? S_CRD : S_AWR;
            S_CRD:  n_state = S_CWR;
            S_CWR:  n_state = (r_i + 1'b1 == r_head) ? S_AWR : S_CRD;
            S_AWR:  n_state = S_EVC;
            S_EVC:  n_state = (32'(r_occ) > w_cap) ? S_ERD : S_OUT;
            S_ERD:  n_state = (r_tail < r_head) ? S_ECHK : S_OUT;
            S_ECHK: n_state = w_q_valid ? S_ETM : S_ERD;
            S_ETM:  n_state = S_EMUL;
            S_EMUL: n_state = S_ESQ;
            S_ESQ:  n_state = S_OUT;
            S_OUT:  n_state = i_res_full ? S_OUT : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_occ   <= '0;
            r_acc   <= '0;
            r_miss  <= '0;
            r_fill  <= '0;
            r_evc   <= '0;
            r_sum   <= '0;
            r_sq    <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                end
                S_IDLE: begin
                    if (!i_mid_empty) begin
                        r_acc <= w_acc_n;
                        if (32'(r_occ) < w_cap) begin
                            r_fill <= w_acc_n;
                        end
                    end
                end
                S_RES: begin
                    if (!w_res_hit) begin
                        r_miss <= f_inc(r_miss);
                    end else if (r_occ != '0) begin
                        r_occ <= r_occ - 1'b1;
                    end
                end
                S_CWR: begin
                    if (r_i + 1'b1 == r_head) begin
                        r_head <= w_q_valid ? r_j + 1'b1 : r_j;
                        r_tail <= '0;
                    end
                end
                S_AWR: begin
                    r_head <= r_head + 1'b1;
                    r_occ  <= r_occ + 1'b1;
                end
                S_ECHK: begin
                    if (w_q_valid) begin
                        if (r_occ != '0) begin
                            r_occ <= r_occ - 1'b1;
                        end
                    end else begin
                        r_tail <= r_tail + 1'b1;
                    end
                end
                S_ETM: begin
                    r_evc <= f_inc(r_evc);
                end
                S_EMUL: begin
                    r_sum <= f_sat_add64(r_sum, 64'(r_age1));
                end
                S_ESQ: begin
                    r_sq <= f_sat_add64(r_sq, r_prod);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_a       <= i_mid_data[AW-1:0];
                r_batch   <= i_mid_data[AW];
                r_ev      <= 1'b0;
                r_evictee <= '0;
                r_age1    <= '0;
                r_age2    <= '0;
            end
            S_RES: begin
                r_hit <= w_res_hit;
            end
            S_APP: begin
                r_i <= '0;
                r_j <= '0;
            end
            S_CWR: begin
                r_i <= r_i + 1'b1;
                if (w_q_valid) begin
                    r_j <= r_j + 1'b1;
                end
            end
            S_ECHK: begin
                if (w_q_valid) begin
                    r_ev      <= 1'b1;
                    r_evictee <= w_q_addr;
                end
            end
            S_ETM: begin
                r_age1 <= f_clip(f_age(r_acc, last_rdata));
                r_age2 <= f_clip(f_age(r_acc, enter_rdata));
            end
            S_EMUL: begin
                r_prod <= 64'(r_age1) * 64'(r_age1);
            end
            default: begin
            end
        endcase
    end

    logic [31:0] w_evictee32;
    assign w_evictee32 = 32'(r_evictee);

    always_comb begin
        o_res.hit            = r_hit;
        o_res.evicted        = r_ev;
        o_res.evictee        = w_evictee32[15:0];
        o_res.since_last_ref = r_age1;
        o_res.since_entered  = r_age2;
        o_res.access_total   = f_clip(r_acc);
        o_res.miss_total     = f_clip(r_miss);
        o_res.fill_mark      = f_clip(r_fill);
        o_res.evict_total    = f_clip(r_evc);
        o_res.age_sum        = r_sum;
        o_res.age_square_sum = r_sq;
        o_res.batch_last     = r_batch;
    end

    assign o_mid_pop  = (r_state == S_IDLE) && !i_mid_empty;
    assign o_res_push = (r_state == S_OUT) && !i_res_full;
    assign o_clearing = (r_state == S_CLR);

endmodule

`default_nettype wire

@@ rtl/lru_et_checker.sv @@
// lru_et_checker: port level checks on the tracker result stream, bound to the top level
// depends on lru_eviction_tracker_top for the bind target
`default_nettype none

module lru_et_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic        o_evicted,
    input wire logic [15:0] o_evictee,
    input wire logic [31:0] o_since_last_ref,
    input wire logic [31:0] o_access_total,
    input wire logic [31:0] o_miss_total,
    input wire logic [31:0] o_evict_total
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_no_evict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_evicted) |-> (o_evictee == 16'd0 && o_since_last_ref == 32'd0))
        else $error("eviction fields set without eviction");

    a_counts_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_evict_total <= o_miss_total && o_miss_total <= o_access_total))
        else $error("running counts out of order");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_access_total)))
        else $error("result beat changed while stalled");

endmodule

bind lru_eviction_tracker_top lru_et_checker u_lru_et_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .empty            (empty),
    .pop              (pop),
    .o_evicted        (o_evicted),
    .o_evictee        (o_evictee),
    .o_since_last_ref (o_since_last_ref),
    .o_access_total   (o_access_total),
    .o_miss_total     (o_miss_total),
    .o_evict_total    (o_evict_total)
);

`default_nettype wire

@@ tb/tb_lru_eviction_tracker_top.sv @@
// tb_lru_eviction_tracker_top: self-checking bench for the lru eviction tracker
// predicts each result with its own lru cache model and checks every field
// depends on lru_et_pkg and lru_eviction_tracker_top
`default_nettype none

module tb_lru_eviction_tracker_top;
    import lru_et_pkg::*;

    localparam int unsigned QDEPTH    = 2048;
    localparam int unsigned CAP_LIMIT = 1024;
    localparam int unsigned WATCHDOG  = 400000;
    localparam logic [63:0] SAT32     = 64'hFFFF_FFFF;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [15:0] i_addr;
    logic        i_batch_end;
    logic        empty;
    logic        pop = 1'b0;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [10:0] i_cfg_data;
    t_result     got;

    lru_eviction_tracker_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full), .i_addr(i_addr), .i_batch_end(i_batch_end),
        .empty(empty), .pop(pop),
        .o_hit(got.hit), .o_evicted(got.evicted), .o_evictee(got.evictee),
        .o_since_last_ref(got.since_last_ref), .o_since_entered(got.since_entered),
        .o_access_total(got.access_total), .o_miss_total(got.miss_total),
        .o_fill_mark(got.fill_mark), .o_evict_total(got.evict_total),
        .o_age_sum(got.age_sum), .o_age_square_sum(got.age_square_sum),
        .o_batch_last(got.batch_last),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    // cache model state
    logic [10:0] capacity;
    bit          resident[ADDR_SPACE_DEF];
    bit [10:0]   slot_of[ADDR_SPACE_DEF];
    bit          slot_live[QDEPTH];
    bit [15:0]   slot_addr[QDEPTH];
    int unsigned head, tail, occupancy;
    bit [63:0]   ref_stamp[ADDR_SPACE_DEF];
    bit [63:0]   entered[ADDR_SPACE_DEF];
    bit [63:0]   accesses, misses, fill_mark, evictions, age_sum, age_sq_sum;

    t_result     expected_results[$];
    int          mismatches = 0;
    int          gap_pct, stall_pct;
    int unsigned idle_cycles = 0;

    function automatic bit [63:0] add_clamped(input bit [63:0] a, input bit [63:0] b);
        bit [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic bit [31:0] clamp32(input bit [63:0] v);
        return (v > SAT32) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic void release_addr(input bit [15:0] a);
        slot_live[slot_of[a]] = 0;
        resident[a] = 0;
        if (occupancy > 0) occupancy--;
    endfunction

    function automatic void insert_recent(input bit [15:0] a, input int unsigned cap);
        int unsigned j;
        if (head >= 2 * cap || head >= QDEPTH) begin
            j = 0;
            for (int unsigned i = 0; i < head && i < QDEPTH; i++) begin
                if (slot_live[i]) begin
                    slot_live[i] = 0;
                    slot_addr[j] = slot_addr[i];
                    slot_live[j] = 1;
                    slot_of[slot_addr[j]] = 11'(j);
                    j++;
                end
            end
            tail = 0;
            head = j;
        end
        slot_addr[head] = a;
        slot_live[head] = 1;
        slot_of[a] = 11'(head);
        resident[a] = 1;
        head++;
        occupancy++;
    endfunction

    function automatic t_result cache_predict(input bit [15:0] a, input bit be);
        t_result     r;
        int unsigned cap;
        bit [63:0]   now, age1, age2;
        bit [15:0]   e;
        r = '0;
        cap = (capacity == 0) ? 1 : (capacity > CAP_LIMIT) ? CAP_LIMIT : capacity;
        if (accesses < SAT32) accesses++;
        now = accesses;
        if (occupancy < cap) fill_mark = now;
        r.hit = resident[a];
        if (!r.hit) begin
            if (misses < SAT32) misses++;
            entered[a] = now;
            ref_stamp[a] = now;
        end else begin
            ref_stamp[a] = now;
            release_addr(a);
        end
        insert_recent(a, cap);
        if (occupancy > cap) begin
            while (tail < head && !slot_live[tail]) tail++;
            if (tail < head) begin
                e = slot_addr[tail];
                release_addr(e);
                age1 = (now >= ref_stamp[e]) ? now - ref_stamp[e] : 0;
                age2 = (now >= entered[e]) ? now - entered[e] : 0;
                r.evicted = 1;
                r.evictee = e;
                r.since_last_ref = clamp32(age1);
                r.since_entered = clamp32(age2);
                if (evictions < SAT32) evictions++;
                age_sum = add_clamped(age_sum, 64'(r.since_last_ref));
                age_sq_sum = add_clamped(age_sq_sum,
                                         64'(r.since_last_ref) * 64'(r.since_last_ref));
            end
        end
        r.access_total = clamp32(accesses);
        r.miss_total = clamp32(misses);
        r.fill_mark = clamp32(fill_mark);
        r.evict_total = clamp32(evictions);
        r.age_sum = age_sum;
        r.age_square_sum = age_sq_sum;
        r.batch_last = be;
        return r;
    endfunction

    // directed rows
    typedef struct {
        bit        wr;
        bit [10:0] cap;
        bit [15:0] addr;
        bit        be;
        bit        known;
        bit        hit;
        bit        ev;
        bit [15:0] evictee;
    } t_row;

    t_row rows[] = '{
        '{0, 0,    16'h0000, 0, 1, 0, 0, 16'h0000},
        '{0, 0,    16'h0000, 1, 1, 1, 0, 16'h0000},
        '{0, 0,    16'hFFFF, 0, 1, 0, 0, 16'h0000},
        '{1, 1,    16'h1234, 0, 1, 0, 1, 16'h0000},
        '{0, 0,    16'h0005, 1, 1, 0, 1, 16'hFFFF},
        '{1, 0,    16'h0005, 0, 1, 1, 1, 16'h1234},
        '{0, 0,    16'h0005, 0, 1, 1, 0, 16'h0000},
        '{0, 0,    16'hAAAA, 1, 1, 0, 1, 16'h0005},
        '{1, 2047, 16'h5555, 0, 1, 0, 0, 16'h0000},
        '{0, 0,    16'h7FFF, 0, 1, 0, 0, 16'h0000},
        '{0, 0,    16'h8000, 1, 1, 0, 0, 16'h0000},
        '{0, 0,    16'h5555, 0, 1, 1, 0, 16'h0000},
        '{1, 2,    16'h0001, 0, 0, 0, 0, 16'h0000},
        '{0, 0,    16'h0002, 0, 0, 0, 0, 16'h0000},
        '{0, 0,    16'h0001, 1, 0, 0, 0, 16'h0000},
        '{0, 0,    16'h0003, 0, 0, 0, 0, 16'h0000},
        '{0, 0,    16'h0002, 0, 0, 0, 0, 16'h0000},
        '{0, 0,    16'h0001, 0, 0, 0, 0, 16'h0000},
        '{0, 0,    16'h0004, 1, 0, 0, 0, 16'h0000},
        '{1, 1024, 16'hFFFF, 0, 0, 0, 0, 16'h0000}
    };

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic wait_drained();
        push <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [10:0] v);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        capacity = v;
    endtask

    task automatic send_ref(input bit [15:0] a, input bit be, input bit known,
                            input bit hit, input bit ev, input bit [15:0] evictee);
        t_result r;
        while ($urandom_range(99) < gap_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_addr <= a;
        i_batch_end <= be;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        r = cache_predict(a, be);
        if (known) begin
            r.hit = hit;
            r.evicted = ev;
            r.evictee = evictee;
        end
        expected_results.push_back(r);
    endtask

    // beat checker and watchdog
    always @(posedge i_clk) begin
        pop <= ($urandom_range(99) >= stall_pct);
        if (i_rst_n && ((push && !full) || (pop && !empty))) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG) begin
            $display("tb_lru_eviction_tracker_top: errors");
            $finish;
        end
        if (i_rst_n && pop && !empty) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat");
            end else begin
                if (expected_results[0] !== got) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", expected_results[0], got);
                end
                void'(expected_results.pop_front());
            end
        end
    end

    int          caps[] = '{3, 1, 8, 0, 2047, 40, 2, 200};
    int unsigned pool, base;
    bit [15:0]   a;

    initial begin
        capacity = CAP_RESET;
        head = 0;
        tail = 0;
        occupancy = 0;
        {accesses, misses, fill_mark, evictions, age_sum, age_sq_sum} = '0;
        gap_pct = 0;
        stall_pct = 0;
        i_rst_n = 1'b0;
        push = 1'b0;
        i_addr = '0;
        i_batch_end = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[k]) begin
            if (rows[k].wr) write_capacity(rows[k].cap);
            send_ref(rows[k].addr, rows[k].be, rows[k].known,
                     rows[k].hit, rows[k].ev, rows[k].evictee);
        end

        foreach (caps[p]) begin
            write_capacity(11'(caps[p]));
            case (p % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 79; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 79; end
                default: begin gap_pct = 17; stall_pct = 17; end
            endcase
            pool = (caps[p] == 0) ? 2 : caps[p] + caps[p] / 2 + 1;
            base = $urandom_range(65535);
            for (int n = 0; n < 154; n++) begin
                if (p == 3 && n == 77) wait_drained();
                if ($urandom_range(99) < 85) a = 16'(base + $urandom_range(pool - 1));
                else a = 16'($urandom);
                send_ref(a, 1'($urandom_range(1)), 0, 0, 0, 0);
            end
        end
        gap_pct = 0;
        stall_pct = 0;
        wait_drained();
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("tb_lru_eviction_tracker_top: clean");
        end else begin
            $display("tb_lru_eviction_tracker_top: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
